### src/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants
// Codes, round constants and the result record of the averaged pump
// hysteresis controller.
// ----------------------------------------------------------------------------
package apc_pkg;

   // transaction kinds on the request channel
   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // channel codes reported in next_channel
   localparam logic [1:0] CHAN_PRESSURE = 2'd0;
   localparam logic [1:0] CHAN_LOW      = 2'd1;
   localparam logic [1:0] CHAN_HIGH     = 2'd2;

   // tick period after reset
   localparam logic [7:0] PERIOD_RESET = 8'd250;

   // sample counter within one acquisition round
   localparam int         IDX_BITS      = 4;
   localparam logic [3:0] PRESSURE_END  = 4'd5;
   localparam logic [3:0] LOW_END       = 4'd10;
   localparam logic [3:0] ROUND_LEN     = 4'd15;

   // divide by five as multiply by reciprocal, exact for sums below 2^16
   localparam int          DIV5_BITS  = 16;
   localparam logic [15:0] DIV5_RECIP = 16'hCCCD;
   localparam int          DIV5_SHIFT = 18;

   // fixed port widths
   localparam int VALUE_BITS = 10;

   typedef struct packed {
      logic                  motor_drive;
      logic                  acquiring;
      logic [1:0]            next_channel;
      logic [VALUE_BITS-1:0] pressure_avg;
      logic [VALUE_BITS-1:0] low_setpoint_avg;
      logic [VALUE_BITS-1:0] high_setpoint_avg;
      logic                  round_done;
   } rsp_type;

endpackage

### src/apc_if.sv
// ----------------------------------------------------------------------------
// apc_if: request and response channels
// Valid/ready channels carrying the controller's input and result items.
// ----------------------------------------------------------------------------
interface apc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [9:0] sample_value;

   modport source (output valid, output kind, output sample_value, input ready);
   modport sink   (input valid, input kind, input sample_value, output ready);
endinterface

interface apc_rsp_if;
   logic       valid;
   logic       ready;
   logic       motor_drive;
   logic       acquiring;
   logic [1:0] next_channel;
   logic [9:0] pressure_avg;
   logic [9:0] low_setpoint_avg;
   logic [9:0] high_setpoint_avg;
   logic       round_done;

   modport source (output valid, output motor_drive, output acquiring,
                   output next_channel, output pressure_avg, output low_setpoint_avg,
                   output high_setpoint_avg, output round_done, input ready);
   modport sink   (input valid, input motor_drive, input acquiring,
                   input next_channel, input pressure_avg, input low_setpoint_avg,
                   input high_setpoint_avg, input round_done, output ready);
endinterface

### src/apc_ctrl.sv
// ----------------------------------------------------------------------------
// apc_ctrl: tick countdown, sample averaging and hysteresis decision
// Updates all controller state for one accepted transaction per cycle and
// forms the matching result record.
// ----------------------------------------------------------------------------
module apc_ctrl #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             accept,
   input  logic             kind,
   input  logic [9:0]       sample_value,
   output apc_pkg::rsp_type rsp_data
);

   localparam int SUM_BITS  = SAMPLE_BITS + 3;
   localparam int IN_BITS   = (SAMPLE_BITS < apc_pkg::VALUE_BITS) ?
                              SAMPLE_BITS : apc_pkg::VALUE_BITS;
   localparam int PROD_BITS = SUM_BITS + apc_pkg::DIV5_BITS;
   localparam int IB        = apc_pkg::IDX_BITS;

   logic [7:0]             tick_period_ff, tick_period_in;
   logic [7:0]             tick_count_ff, tick_count_in;
   logic                   in_round_ff, in_round_in;
   logic [IB-1:0]          sample_index_ff, sample_index_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] pressure_ff, pressure_in;
   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [SAMPLE_BITS-1:0] high_ff, high_in;
   logic                   motor_ff, motor_in;
   logic                   done;

   logic [SAMPLE_BITS-1:0] sample_ext;
   logic [SUM_BITS-1:0]    sum_add;
   logic [IB-1:0]          idx_inc;
   logic [PROD_BITS-1:0]   prod;
   logic [SAMPLE_BITS-1:0] avg;
   logic [7:0]             count_dec;

   // take the low sample bits and extend into the running sum
   assign sample_ext = SAMPLE_BITS'(sample_value[IN_BITS-1:0]);
   assign sum_add    = sum_ff + SUM_BITS'(sample_ext);
   assign idx_inc    = sample_index_ff + IB'(1);

   // average of five: multiply by reciprocal, keep the quotient bits
   assign prod = PROD_BITS'(sum_add) * PROD_BITS'(apc_pkg::DIV5_RECIP);
   assign avg  = prod[apc_pkg::DIV5_SHIFT +: SAMPLE_BITS];

   // count down, hold at zero
   assign count_dec = (tick_count_ff != 8'd0) ? tick_count_ff - 8'd1 : tick_count_ff;

   // next state for one transaction
   always_comb begin
      tick_period_in  = csr_wr_en ? csr_wr_data : tick_period_ff;
      tick_count_in   = tick_count_ff;
      in_round_in     = in_round_ff;
      sample_index_in = sample_index_ff;
      sum_in          = sum_ff;
      pressure_in     = pressure_ff;
      low_in          = low_ff;
      high_in         = high_ff;
      motor_in        = motor_ff;
      done            = 1'b0;
      if (accept) begin
         if (kind == apc_pkg::KIND_TICK) begin
            // ticks advance the countdown only between rounds
            if (!in_round_ff) begin
               tick_count_in = count_dec;
               if (count_dec == 8'd0) begin
                  in_round_in     = 1'b1;
                  sample_index_in = '0;
                  sum_in          = '0;
               end
            end
         end else if (in_round_ff) begin
            sum_in          = sum_add;
            sample_index_in = idx_inc;
            // close a group of five and latch its average
            if (idx_inc == apc_pkg::PRESSURE_END || idx_inc == apc_pkg::LOW_END ||
                idx_inc == apc_pkg::ROUND_LEN) begin
               sum_in = '0;
               if (idx_inc == apc_pkg::PRESSURE_END) begin
                  pressure_in = avg;
               end else if (idx_inc == apc_pkg::LOW_END) begin
                  low_in = avg;
               end else begin
                  high_in = avg;
               end
            end
            // end of round: decide motor and reload the countdown
            if (idx_inc >= apc_pkg::ROUND_LEN) begin
               motor_in        = (pressure_in > high_in) &&
                                 (motor_ff || (pressure_in > low_in));
               in_round_in     = 1'b0;
               sample_index_in = '0;
               tick_count_in   = tick_period_ff;
               done            = 1'b1;
            end
         end
      end
   end

   // build the result record from the updated state
   always_comb begin
      rsp_data.motor_drive  = motor_in;
      rsp_data.acquiring    = in_round_in;
      rsp_data.next_channel = apc_pkg::CHAN_PRESSURE;
      if (in_round_in) begin
         if (sample_index_in >= apc_pkg::LOW_END) begin
            rsp_data.next_channel = apc_pkg::CHAN_HIGH;
         end else if (sample_index_in >= apc_pkg::PRESSURE_END) begin
            rsp_data.next_channel = apc_pkg::CHAN_LOW;
         end
      end
      rsp_data.pressure_avg      = apc_pkg::VALUE_BITS'(pressure_in);
      rsp_data.low_setpoint_avg  = apc_pkg::VALUE_BITS'(low_in);
      rsp_data.high_setpoint_avg = apc_pkg::VALUE_BITS'(high_in);
      rsp_data.round_done        = done;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff  <= apc_pkg::PERIOD_RESET;
         tick_count_ff   <= apc_pkg::PERIOD_RESET;
         in_round_ff     <= 1'b0;
         sample_index_ff <= '0;
         sum_ff          <= '0;
         pressure_ff     <= '0;
         low_ff          <= '0;
         high_ff         <= '0;
         motor_ff        <= 1'b0;
      end else begin
         tick_period_ff  <= tick_period_in;
         tick_count_ff   <= tick_count_in;
         in_round_ff     <= in_round_in;
         sample_index_ff <= sample_index_in;
         sum_ff          <= sum_in;
         pressure_ff     <= pressure_in;
         low_ff          <= low_in;
         high_ff         <= high_in;
         motor_ff        <= motor_in;
      end
   end

   // sample counter rests at zero between rounds
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !in_round_ff |-> sample_index_ff == '0)
      else $error("sample index nonzero outside a round");

   // sample counter never reaches the round length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      sample_index_ff < apc_pkg::ROUND_LEN)
      else $error("sample index out of range");

   // a finished round closes and reloads the countdown
   a_round_reload: assert property (@(posedge clock) disable iff (reset)
      done |=> !in_round_ff && tick_count_ff == $past(tick_period_ff))
      else $error("round end did not reload countdown");

endmodule

### src/apc_rsp_buf.sv
// ----------------------------------------------------------------------------
// apc_rsp_buf: two-entry result buffer
// Holds result records so a new transaction is taken while an earlier
// result still waits on the response channel.
// ----------------------------------------------------------------------------
module apc_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  apc_pkg::rsp_type push_data,
   output logic             room,
   output logic             out_valid,
   input  logic             out_ready,
   output apc_pkg::rsp_type out_data
);

   apc_pkg::rsp_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign room      = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   // store pushed records
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // never push into a full buffer
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != 2'd2)
      else $error("push into full result buffer");

   // occupancy stays within two entries
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer occupancy out of range");

   // hold the head record while it waits on the response channel
   a_hold_head: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
      else $error("waiting result record changed");

endmodule

### src/averaged_pump_hysteresis_control.sv
// ----------------------------------------------------------------------------
// averaged_pump_hysteresis_control: averaged bang-bang pump controller
// Counts millisecond ticks, averages fifteen converter samples per round and
// switches the pump motor with hysteresis between two setpoints.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Contents
//   req_chan  in         valid/ready          kind, sample_value
//   rsp_chan  out        valid/ready          motor, round state, averages
//   csr_*     in         csr_wr_en            tick_period (8 bits)
//
// One transaction is accepted per cycle whenever the result buffer has room.
// All arithmetic (sum, divide by five via reciprocal, compares) sits between
// the request accept and the two-entry result buffer.
// req_chan.ready drops only while both result buffer entries are waiting.
// Synchronous reset restores tick_period and the countdown to 250, motor off.
//
module averaged_pump_hysteresis_control #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   apc_req_if.sink    req_chan,
   apc_rsp_if.source  rsp_chan
);

   logic             accept;
   logic             room;
   apc_pkg::rsp_type ctrl_rsp;
   apc_pkg::rsp_type buf_rsp;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   apc_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .kind         (req_chan.kind),
      .sample_value (req_chan.sample_value),
      .rsp_data     (ctrl_rsp)
   );

   apc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (ctrl_rsp),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (buf_rsp)
   );

   // drive the response channel fields
   assign rsp_chan.motor_drive       = buf_rsp.motor_drive;
   assign rsp_chan.acquiring         = buf_rsp.acquiring;
   assign rsp_chan.next_channel      = buf_rsp.next_channel;
   assign rsp_chan.pressure_avg      = buf_rsp.pressure_avg;
   assign rsp_chan.low_setpoint_avg  = buf_rsp.low_setpoint_avg;
   assign rsp_chan.high_setpoint_avg = buf_rsp.high_setpoint_avg;
   assign rsp_chan.round_done        = buf_rsp.round_done;

endmodule

### tb/pump_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_tb_pkg: result scoreboard for the pump controller bench
// Mirrors the tick countdown, the fifteen-sample acquisition round and the
// hysteresis switch, and compares each response against the oldest
// predicted one.
// ----------------------------------------------------------------------------
package pump_tb_pkg;

   localparam int GROUP_LEN  = 5;
   localparam int MAX_REPORT = 10;

   class pump_scoreboard;
      // mirrored controller state
      logic [7:0]  period;
      logic [7:0]  count;
      bit          in_round;
      logic [3:0]  sample_idx;
      logic [12:0] acc_sum;
      logic [9:0]  pressure_avg;
      logic [9:0]  low_avg;
      logic [9:0]  high_avg;
      bit          motor_on;

      // predicted responses, oldest first
      apc_pkg::rsp_type predicted_q[$];

      int          mismatches;
      int          accepted;
      int          checked;
      int          ignored;
      int          rounds;
      int          motor_rounds;

      function new();
         period       = apc_pkg::PERIOD_RESET;
         count        = apc_pkg::PERIOD_RESET;
         in_round     = 1'b0;
         sample_idx   = '0;
         acc_sum      = '0;
         pressure_avg = '0;
         low_avg      = '0;
         high_avg     = '0;
         motor_on     = 1'b0;
      endfunction

      function void set_period(logic [7:0] value);
         period = value;
      endfunction

      function int pending();
         return predicted_q.size();
      endfunction

      // channel the open round wants next
      function logic [1:0] current_channel();
         if (!in_round || sample_idx < apc_pkg::PRESSURE_END)
            return apc_pkg::CHAN_PRESSURE;
         else if (sample_idx < apc_pkg::LOW_END)
            return apc_pkg::CHAN_LOW;
         else
            return apc_pkg::CHAN_HIGH;
      endfunction

      // advance the mirrored state by one accepted transaction
      function void note_request(logic kind, logic [9:0] value);
         int               next_idx;
         logic [9:0]       avg;
         apc_pkg::rsp_type rsp;
         bit               done;

         done = 1'b0;
         accepted++;
         if (kind == apc_pkg::KIND_TICK) begin
            if (in_round) begin
               ignored++;
            end else begin
               if (count != 0)
                  count--;
               if (count == 0) begin
                  in_round   = 1'b1;
                  sample_idx = '0;
                  acc_sum    = '0;
               end
            end
         end else if (!in_round) begin
            ignored++;
         end else begin
            // accumulate, close a group of five, close the round at fifteen
            acc_sum  = acc_sum + 13'(value);
            next_idx = sample_idx + 1;
            if (next_idx % GROUP_LEN == 0) begin
               avg = 10'(acc_sum / GROUP_LEN);
               if (next_idx == apc_pkg::PRESSURE_END)
                  pressure_avg = avg;
               else if (next_idx == apc_pkg::LOW_END)
                  low_avg = avg;
               else
                  high_avg = avg;
               acc_sum = '0;
            end
            if (next_idx >= apc_pkg::ROUND_LEN) begin
               motor_on   = (pressure_avg > high_avg) &&
                            (motor_on || pressure_avg > low_avg);
               in_round   = 1'b0;
               sample_idx = '0;
               count      = period;
               done       = 1'b1;
               rounds++;
               if (motor_on)
                  motor_rounds++;
            end else begin
               sample_idx = 4'(next_idx);
            end
         end

         rsp.motor_drive       = motor_on;
         rsp.acquiring         = in_round;
         rsp.next_channel      = current_channel();
         rsp.pressure_avg      = pressure_avg;
         rsp.low_setpoint_avg  = low_avg;
         rsp.high_setpoint_avg = high_avg;
         rsp.round_done        = done;
         predicted_q.push_back(rsp);
      endfunction

      // compare one accepted response against the oldest prediction
      function void check_result(apc_pkg::rsp_type got);
         apc_pkg::rsp_type want;
         bit               bad;

         checked++;
         if (predicted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display("%0t: response with nothing predicted: motor=%0b acq=%0b",
                        $time, got.motor_drive, got.acquiring);
            return;
         end
         want = predicted_q.pop_front();
         bad  = (got.motor_drive       !== want.motor_drive)      ||
                (got.acquiring         !== want.acquiring)        ||
                (got.next_channel      !== want.next_channel)     ||
                (got.pressure_avg      !== want.pressure_avg)     ||
                (got.low_setpoint_avg  !== want.low_setpoint_avg) ||
                (got.high_setpoint_avg !== want.high_setpoint_avg)||
                (got.round_done        !== want.round_done);
         if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORT) begin
               $display("%0t: mismatch on response %0d", $time, checked);
               $display("   expected motor=%0b acq=%0b chan=%0d p=%0d lo=%0d hi=%0d done=%0b",
                        want.motor_drive, want.acquiring, want.next_channel,
                        want.pressure_avg, want.low_setpoint_avg,
                        want.high_setpoint_avg, want.round_done);
               $display("   actual   motor=%0b acq=%0b chan=%0d p=%0d lo=%0d hi=%0d done=%0b",
                        got.motor_drive, got.acquiring, got.next_channel,
                        got.pressure_avg, got.low_setpoint_avg,
                        got.high_setpoint_avg, got.round_done);
            end
         end
      endfunction
   endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the averaged pump hysteresis controller
// Counts down the reset period, runs a directed round with a period change
// in mid-round, then random phases over several tick periods with mostly
// well-formed rounds, random idling on both channels and one long response
// hold-off. Every response is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  HOLD_CYCLES  = 64;
   localparam int  IDLE_PERCENT = 8;
   localparam time LIMIT_NS     = 800_000;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   // shared between sender and receiver
   bit         quiet;
   bit         hold_pending;
   int         holds_done;

   int         targets[3];

   pump_tb_pkg::pump_scoreboard sb;

   apc_req_if req_chan ();
   apc_rsp_if rsp_chan ();

   averaged_pump_hysteresis_control DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // offer one transaction, idling first now and then; return at its accept edge
   task automatic send(input logic kind, input logic [9:0] value);
      int gap;
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.kind         <= kind;
      req_chan.sample_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(kind, value);
   endtask

   // drop valid and wait until every predicted response has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_period(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_period(value);
      csr_wr_en   <= 1'b0;
   endtask

   // sample near the round's target for a channel, with some outliers
   function automatic logic [9:0] pick_sample(logic [1:0] chan);
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 8)
         return 10'($urandom_range(1023));
      if (r < 11)
         return 10'd0;
      if (r < 14)
         return 10'h3FF;
      v = targets[chan] + $urandom_range(6) - 3;
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return 10'(v);
   endfunction

   // response receiver: random stalls, quiet stretch, one long hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // check every accepted response
   always @(posedge clock) begin
      apc_pkg::rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.motor_drive       = rsp_chan.motor_drive;
         got.acquiring         = rsp_chan.acquiring;
         got.next_channel      = rsp_chan.next_channel;
         got.pressure_avg      = rsp_chan.pressure_avg;
         got.low_setpoint_avg  = rsp_chan.low_setpoint_avg;
         got.high_setpoint_avg = rsp_chan.high_setpoint_avg;
         got.round_done        = rsp_chan.round_done;
         sb.check_result(got);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // stimulus
   initial begin
      int phase_period[8];
      int phase_items[8];
      int effective;
      int span;
      int lo_t;
      int hi_t;
      bit hold_issued;
      logic [7:0] period;
      logic [1:0] chan;

      phase_period = '{1, 0, 3, 255, 2, 250, -1, 1};
      phase_items  = '{200, 160, 160, 240, 160, 230, 200, 150};
      sb           = new();
      hold_issued  = 1'b0;

      reset                 <= 1'b1;
      csr_wr_en             <= 1'b0;
      csr_wr_data           <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.kind         <= apc_pkg::KIND_TICK;
      req_chan.sample_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // samples outside a round are dropped
      send(apc_pkg::KIND_SAMPLE, 10'h3FF);
      send(apc_pkg::KIND_SAMPLE, 10'h000);

      // count down the reset period until the first round opens
      while (!sb.in_round)
         send(apc_pkg::KIND_TICK, 10'($urandom_range(1023)));

      // tick inside a round is dropped
      send(apc_pkg::KIND_TICK, 10'h3FF);

      // full-scale pressure, zero setpoints: motor must start
      repeat (5) send(apc_pkg::KIND_SAMPLE, 10'h3FF);
      repeat (2) send(apc_pkg::KIND_SAMPLE, 10'h000);

      // change the period in mid-round; it applies at the reload
      wait_drained();
      write_period(8'd1);
      repeat (3) send(apc_pkg::KIND_SAMPLE, 10'h000);
      repeat (5) send(apc_pkg::KIND_SAMPLE, 10'h000);

      // random phases over a spread of periods
      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         period = (phase_period[ph] < 0) ? 8'($urandom_range(4, 40))
                                         : 8'(phase_period[ph]);
         write_period(period);
         quiet     = (ph == 2);
         effective = 0;
         while (effective < phase_items[ph]) begin
            if (sb.in_round) begin
               // new targets before a round's first sample
               if (sb.sample_idx == 0) begin
                  targets[apc_pkg::CHAN_LOW]  = $urandom_range(1023);
                  targets[apc_pkg::CHAN_HIGH] = $urandom_range(1023);
                  lo_t = (targets[apc_pkg::CHAN_LOW] < targets[apc_pkg::CHAN_HIGH]) ?
                         targets[apc_pkg::CHAN_LOW] : targets[apc_pkg::CHAN_HIGH];
                  hi_t = (targets[apc_pkg::CHAN_LOW] < targets[apc_pkg::CHAN_HIGH]) ?
                         targets[apc_pkg::CHAN_HIGH] : targets[apc_pkg::CHAN_LOW];
                  span = $urandom_range(99);
                  if (span < 35)
                     targets[apc_pkg::CHAN_PRESSURE] =
                        targets[apc_pkg::CHAN_HIGH] + $urandom_range(4) - 2;
                  else if (span < 55)
                     targets[apc_pkg::CHAN_PRESSURE] =
                        targets[apc_pkg::CHAN_LOW] + $urandom_range(4) - 2;
                  else if (span < 75)
                     targets[apc_pkg::CHAN_PRESSURE] = $urandom_range(hi_t, lo_t);
                  else
                     targets[apc_pkg::CHAN_PRESSURE] = $urandom_range(1023);
               end
               chan = sb.current_channel();
               if ($urandom_range(99) < 6) begin
                  send(apc_pkg::KIND_TICK, 10'($urandom_range(1023)));
               end else begin
                  send(apc_pkg::KIND_SAMPLE, pick_sample(chan));
                  effective++;
               end
            end else begin
               if ($urandom_range(99) < 8) begin
                  send(apc_pkg::KIND_SAMPLE, 10'($urandom_range(1023)));
               end else begin
                  send(apc_pkg::KIND_TICK, 10'($urandom_range(1023)));
                  effective++;
               end
            end
            // stall the response side while requests keep coming
            if (ph == 0 && effective == 120 && !hold_issued) begin
               hold_pending = 1'b1;
               hold_issued  = 1'b1;
            end
         end
      end

      quiet = 1'b0;
      wait_drained();

      $display("Run: %0d transactions, %0d responses checked, %0d ignored by the block",
               sb.accepted, sb.checked, sb.ignored);
      $display("Rounds: %0d completed, %0d left the motor on, %0d response hold-offs",
               sb.rounds, sb.motor_rounds, holds_done);
      if (sb.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
src/apc_pkg.sv
src/apc_if.sv
src/apc_ctrl.sv
src/apc_rsp_buf.sv
src/averaged_pump_hysteresis_control.sv
tb/pump_tb_pkg.sv
tb/tb_top.sv
